FILE: rtl/pss_pkg.sv
// Pump supervisor package: shared types, codes and event builders.
// Used by pss_cfg, pss_ctrl, pss_dp and pump_supervisor_fsm.
// No dependencies.
package pss_pkg;

  // Pump modes, also the pump_state code of a status event
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_PRIMING  = 3'd1,
    MODE_RUNNING  = 3'd2,
    MODE_STOPPING = 3'd3,
    MODE_FAULT    = 3'd4
  } mode_t;

  // Request codes
  localparam logic [3:0] REQ_START  = 4'd0;
  localparam logic [3:0] REQ_STOP   = 4'd1;
  localparam logic [3:0] REQ_ESTOP  = 4'd2;
  localparam logic [3:0] REQ_RESET  = 4'd3;
  localparam logic [3:0] REQ_SETSPD = 4'd4;
  localparam logic [3:0] REQ_QUERY  = 4'd5;
  localparam logic [3:0] REQ_TICK   = 4'd6;
  localparam logic [3:0] REQ_GUI_HB = 4'd7;
  localparam logic [3:0] REQ_GUI_LOST = 4'd8;

  // Alarm codes
  localparam logic [2:0] ALM_NONE         = 3'd0;
  localparam logic [2:0] ALM_ESTOP_REMOTE = 3'd1;
  localparam logic [2:0] ALM_ESTOP_LOCAL  = 3'd2;
  localparam logic [2:0] ALM_OVER_TEMP    = 3'd3;
  localparam logic [2:0] ALM_TEMP_HIGH    = 3'd4;
  localparam logic [2:0] ALM_VIB_HIGH     = 3'd5;
  localparam logic [2:0] ALM_VIB_TRIP     = 3'd6;
  localparam logic [2:0] ALM_GUI_LOST     = 3'd7;

  // Ramp modes
  localparam logic [1:0] RAMP_UP    = 2'd0;
  localparam logic [1:0] RAMP_DOWN  = 2'd1;
  localparam logic [1:0] RAMP_COAST = 2'd2;

  // Event kinds
  localparam logic EV_STATUS = 1'b0;
  localparam logic EV_ALARM  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMP_TRIP  = 3'd0;
  localparam logic [2:0] REG_TEMP_WARN  = 3'd1;
  localparam logic [2:0] REG_TEMP_RESET = 3'd2;
  localparam logic [2:0] REG_VIB_WARN   = 3'd3;
  localparam logic [2:0] REG_VIB_TRIP   = 3'd4;
  localparam logic [2:0] REG_VIB_TICKS  = 3'd5;
  localparam logic [2:0] REG_PRIME_TICKS = 3'd6;
  localparam logic [2:0] REG_STOP_SPEED = 3'd7;

  localparam int QDEPTH = 8;

  typedef struct packed {
    logic signed [11:0] temp_trip_level;
    logic signed [11:0] temp_warn_level;
    logic signed [11:0] temp_reset_level;
    logic [13:0]        vib_warn_level;
    logic [13:0]        vib_trip_level;
    logic [15:0]        vib_trip_ticks;
    logic [15:0]        prime_ticks;
    logic [15:0]        stopped_speed;
  } cfg_t;

  // Datapath operations issued by the sequencer
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ENTER,
    OP_STATUS,
    OP_ALARM,
    OP_REPUB,
    OP_SETPT,
    OP_TICK,
    OP_TURN,
    OP_VCNT,
    OP_GUI
  } op_t;

  typedef struct packed {
    op_t        op;
    mode_t      mode;
    logic [2:0] code;
    logic       sev;
    logic       on;
    logic       drain;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] req;
    mode_t      mode;
    logic [2:0] latched_fault;
    logic       gui_online;
    logic       btn_edge;
    logic       prime_done;
    logic       reset_refused;
    logic       stopped;
    logic       temp_trip;
    logic       twarn_set;
    logic       twarn_clr;
    logic       vwarn_set;
    logic       vwarn_clr;
    logic       vib_trip;
    logic       drained;
  } dp_stat_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_RST_E,
    S_HB_A,
    S_HB_S,
    S_LOST_A,
    S_LOST_E,
    S_REPUB,
    S_T_BTN,
    S_T_MODE,
    S_T_TURN,
    S_T_TEMP,
    S_T_TW,
    S_T_VW,
    S_T_VC,
    S_T_VIB,
    S_TRIP_E,
    S_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  state;
    logic [2:0]  fault;
    logic [15:0] setpoint;
    logic [15:0] target;
    logic [1:0]  ramp;
    logic [2:0]  acode;
    logic        sev;
    logic        active;
  } event_t;

  function automatic event_t mk_status(mode_t m, logic [2:0] fc, logic [15:0] sp,
                                       logic [15:0] prime_speed);
    event_t e;
    e = '0;
    e.kind     = EV_STATUS;
    e.state    = m;
    e.fault    = fc;
    e.setpoint = sp;
    case (m)
      MODE_PRIMING:  e.target = prime_speed;
      MODE_RUNNING:  e.target = sp;
      default:       e.target = '0;
    endcase
    case (m)
      MODE_STOPPING: e.ramp = RAMP_DOWN;
      MODE_FAULT:    e.ramp = RAMP_COAST;
      default:       e.ramp = RAMP_UP;
    endcase
    return e;
  endfunction

  function automatic event_t mk_alarm(logic [2:0] code, logic sev, logic on);
    event_t e;
    e = '0;
    e.kind   = EV_ALARM;
    e.acode  = code;
    e.sev    = sev;
    e.active = on;
    return e;
  endfunction

endpackage

FILE: rtl/pss_cfg.sv
// Pump supervisor configuration registers behind an APB-style port.
// Depends on pss_pkg (cfg_t, register indexes).
module pss_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pss_pkg::cfg_t cfg
);
  import pss_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TEMP_TRIP:   cfg_nxt.temp_trip_level  = pwdata[11:0];
        REG_TEMP_WARN:   cfg_nxt.temp_warn_level  = pwdata[11:0];
        REG_TEMP_RESET:  cfg_nxt.temp_reset_level = pwdata[11:0];
        REG_VIB_WARN:    cfg_nxt.vib_warn_level   = pwdata[13:0];
        REG_VIB_TRIP:    cfg_nxt.vib_trip_level   = pwdata[13:0];
        REG_VIB_TICKS:   cfg_nxt.vib_trip_ticks   = pwdata[15:0];
        REG_PRIME_TICKS: cfg_nxt.prime_ticks      = pwdata[15:0];
        REG_STOP_SPEED:  cfg_nxt.stopped_speed    = pwdata[15:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_trip_level  <= 12'sd900;
      cfg_r.temp_warn_level  <= 12'sd800;
      cfg_r.temp_reset_level <= 12'sd600;
      cfg_r.vib_warn_level   <= 14'd2000;
      cfg_r.vib_trip_level   <= 14'd4000;
      cfg_r.vib_trip_ticks   <= 16'd20;
      cfg_r.prime_ticks      <= 16'd40;
      cfg_r.stopped_speed    <= 16'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_TEMP_TRIP:   prdata = {20'd0, cfg_r.temp_trip_level};
      REG_TEMP_WARN:   prdata = {20'd0, cfg_r.temp_warn_level};
      REG_TEMP_RESET:  prdata = {20'd0, cfg_r.temp_reset_level};
      REG_VIB_WARN:    prdata = {18'd0, cfg_r.vib_warn_level};
      REG_VIB_TRIP:    prdata = {18'd0, cfg_r.vib_trip_level};
      REG_VIB_TICKS:   prdata = {16'd0, cfg_r.vib_trip_ticks};
      REG_PRIME_TICKS: prdata = {16'd0, cfg_r.prime_ticks};
      REG_STOP_SPEED:  prdata = {16'd0, cfg_r.stopped_speed};
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/pss_ctrl.sv
// Pump supervisor sequencer: walks each request through its steps, one
// datapath operation per cycle, then drains the event queue.
// Depends on pss_pkg (ctrl_state_t, dp_cmd_t, dp_stat_t, codes).
module pss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pss_pkg::dp_stat_t stat,
  output pss_pkg::dp_cmd_t  cmd
);
  import pss_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [2:0]  rep_r, rep_nxt;   // alarm code being republished
  logic [2:0]  trip_r, trip_nxt; // fault code of the trip in progress
  logic        not_fault;
  logic        pri_or_run;

  assign not_fault  = (stat.mode != MODE_FAULT);
  assign pri_or_run = (stat.mode == MODE_PRIMING) || (stat.mode == MODE_RUNNING);
  assign in_stall   = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rep_r   <= ALM_NONE;
      trip_r  <= ALM_NONE;
    end else begin
      state_r <= state_nxt;
      rep_r   <= rep_nxt;
      trip_r  <= trip_nxt;
    end
  end

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    rep_nxt   = rep_r;
    trip_nxt  = trip_r;
    cmd       = '{op: OP_NONE, mode: MODE_IDLE, code: ALM_NONE, sev: 1'b0,
                  on: 1'b0, drain: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_nxt = S_DRAIN;
        case (stat.req)
          REQ_START: begin
            if (stat.mode == MODE_IDLE) begin
              cmd.op   = OP_ENTER;
              cmd.mode = MODE_PRIMING;
            end
          end
          REQ_STOP: begin
            if (pri_or_run) begin
              cmd.op   = OP_ENTER;
              cmd.mode = MODE_STOPPING;
            end
          end
          REQ_ESTOP: begin
            if (not_fault) begin
              cmd.op    = OP_ALARM;
              cmd.code  = ALM_ESTOP_REMOTE;
              cmd.sev   = 1'b1;
              cmd.on    = 1'b1;
              trip_nxt  = ALM_ESTOP_REMOTE;
              state_nxt = S_TRIP_E;
            end
          end
          REQ_RESET: begin
            if (!not_fault) begin
              if (stat.reset_refused) begin
                cmd.op = OP_STATUS;
              end else begin
                cmd.op    = OP_ALARM;
                cmd.code  = stat.latched_fault;
                cmd.sev   = 1'b1;
                cmd.on    = 1'b0;
                state_nxt = S_RST_E;
              end
            end
          end
          REQ_SETSPD: cmd.op = OP_SETPT;
          REQ_QUERY: begin
            cmd.op    = OP_STATUS;
            rep_nxt   = ALM_ESTOP_REMOTE;
            state_nxt = S_REPUB;
          end
          REQ_TICK: begin
            cmd.op    = OP_TICK;
            state_nxt = S_T_BTN;
          end
          REQ_GUI_HB: begin
            if (!stat.gui_online) begin
              cmd.op    = OP_GUI;
              cmd.on    = 1'b1;
              state_nxt = S_HB_A;
            end
          end
          REQ_GUI_LOST: begin
            cmd.op = OP_GUI;
            cmd.on = 1'b0;
            if (pri_or_run) state_nxt = S_LOST_A;
          end
          default: state_nxt = S_DRAIN;
        endcase
      end

      S_RST_E: begin
        cmd.op    = OP_ENTER;
        cmd.mode  = MODE_IDLE;
        state_nxt = S_DRAIN;
      end

      // Heartbeat after link loss
      S_HB_A: begin
        cmd.op    = OP_ALARM;
        cmd.code  = ALM_GUI_LOST;
        state_nxt = S_HB_S;
      end
      S_HB_S: begin
        cmd.op    = OP_STATUS;
        rep_nxt   = ALM_ESTOP_REMOTE;
        state_nxt = S_REPUB;
      end

      // Link lost while turning under drive
      S_LOST_A: begin
        cmd.op    = OP_ALARM;
        cmd.code  = ALM_GUI_LOST;
        cmd.on    = 1'b1;
        state_nxt = S_LOST_E;
      end
      S_LOST_E: begin
        cmd.op    = OP_ENTER;
        cmd.mode  = MODE_STOPPING;
        state_nxt = S_DRAIN;
      end

      // Republish every raised alarm, codes one to seven
      S_REPUB: begin
        cmd.op   = OP_REPUB;
        cmd.code = rep_r;
        if (rep_r == ALM_GUI_LOST) state_nxt = S_DRAIN;
        else rep_nxt = rep_r + 3'd1;
      end

      // Tick steps
      S_T_BTN: begin
        state_nxt = S_T_MODE;
        if (stat.btn_edge && not_fault) begin
          cmd.op    = OP_ALARM;
          cmd.code  = ALM_ESTOP_LOCAL;
          cmd.sev   = 1'b1;
          cmd.on    = 1'b1;
          trip_nxt  = ALM_ESTOP_LOCAL;
          state_nxt = S_TRIP_E;
        end
      end
      S_T_MODE: begin
        state_nxt = S_T_TURN;
        if (stat.mode == MODE_PRIMING && stat.prime_done) begin
          cmd.op   = OP_ENTER;
          cmd.mode = MODE_RUNNING;
        end else if (stat.mode == MODE_STOPPING && stat.stopped) begin
          cmd.op   = OP_ENTER;
          cmd.mode = MODE_IDLE;
        end
      end
      S_T_TURN: begin
        cmd.op    = OP_TURN;
        state_nxt = S_T_TEMP;
      end
      S_T_TEMP: begin
        state_nxt = S_T_TW;
        if (stat.temp_trip && not_fault) begin
          cmd.op    = OP_ALARM;
          cmd.code  = ALM_OVER_TEMP;
          cmd.sev   = 1'b1;
          cmd.on    = 1'b1;
          trip_nxt  = ALM_OVER_TEMP;
          state_nxt = S_TRIP_E;
        end
      end
      S_T_TW: begin
        state_nxt = S_T_VW;
        if (stat.twarn_set || stat.twarn_clr) begin
          cmd.op   = OP_ALARM;
          cmd.code = ALM_TEMP_HIGH;
          cmd.on   = stat.twarn_set;
        end
      end
      S_T_VW: begin
        state_nxt = S_T_VC;
        if (stat.vwarn_set || stat.vwarn_clr) begin
          cmd.op   = OP_ALARM;
          cmd.code = ALM_VIB_HIGH;
          cmd.on   = stat.vwarn_set;
        end
      end
      S_T_VC: begin
        cmd.op    = OP_VCNT;
        state_nxt = S_T_VIB;
      end
      S_T_VIB: begin
        state_nxt = S_DRAIN;
        if (stat.vib_trip && not_fault) begin
          cmd.op    = OP_ALARM;
          cmd.code  = ALM_VIB_TRIP;
          cmd.sev   = 1'b1;
          cmd.on    = 1'b1;
          trip_nxt  = ALM_VIB_TRIP;
          state_nxt = S_TRIP_E;
        end
      end

      // Second half of a trip: latch the fault; resume where it came from
      S_TRIP_E: begin
        cmd.op   = OP_ENTER;
        cmd.mode = MODE_FAULT;
        cmd.code = trip_r;
        case (trip_r)
          ALM_ESTOP_LOCAL: state_nxt = S_T_MODE;
          ALM_OVER_TEMP:   state_nxt = S_T_TW;
          default:         state_nxt = S_DRAIN;
        endcase
      end

      S_DRAIN: begin
        cmd.drain = 1'b1;
        if (stat.drained) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/pss_dp.sv
// Pump supervisor datapath: pump state, alarm flags, protection compares
// and the eight-entry event queue that feeds the result channel.
// Depends on pss_pkg (cfg_t, dp_cmd_t, dp_stat_t, event_t, builders).
module pss_dp #(
  parameter int MIN_SETPOINT     = 500,
  parameter int MAX_SETPOINT     = 3000,
  parameter int DEFAULT_SETPOINT = 1500,
  parameter int PRIME_SPEED      = 800
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pss_pkg::dp_cmd_t   cmd,
  input  pss_pkg::cfg_t      cfg,
  output pss_pkg::dp_stat_t  stat,
  input  logic [3:0]         in_req_type,
  input  logic [15:0]        in_speed_request,
  input  logic [15:0]        in_motor_speed,
  input  logic signed [11:0] in_motor_temp,
  input  logic [13:0]        in_vibration,
  input  logic               in_stop_button,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_event_kind,
  output logic [2:0]         out_pump_state,
  output logic [2:0]         out_fault_code,
  output logic [15:0]        out_setpoint,
  output logic [15:0]        out_target_speed,
  output logic [1:0]         out_ramp_mode,
  output logic [2:0]         out_alarm_code,
  output logic               out_alarm_severity,
  output logic               out_alarm_active,
  output logic               out_last
);
  import pss_pkg::*;

  localparam logic [15:0] MIN_SP   = 16'(MIN_SETPOINT);
  localparam logic [15:0] MAX_SP   = 16'(MAX_SETPOINT);
  localparam logic [15:0] DEF_SP   = 16'(DEFAULT_SETPOINT);
  localparam logic [15:0] PRIME_SP = 16'(PRIME_SPEED);
  localparam logic [15:0] CNT_MAX  = 16'hFFFF;
  localparam logic [3:0]  QFULL    = 4'(QDEPTH);

  // Captured item
  logic [3:0]         req_r;
  logic [15:0]        sreq_r, spd_r;
  logic signed [11:0] temp_r;
  logic [13:0]        vib_r;
  logic               btn_r;

  // Pump state
  mode_t       mode_r, mode_nxt;
  logic [2:0]  lf_r, lf_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [15:0] tim_r, tim_nxt;
  logic [15:0] vot_r, vot_nxt;
  logic        bwp_r, bwp_nxt;
  logic        gui_r, gui_nxt;
  logic [6:0]  aflag_r, aflag_nxt;
  logic [6:0]  asev_r, asev_nxt;
  logic        bedge_r, bedge_nxt;
  logic        turn_r, turn_nxt;

  // Event queue
  event_t      q_r [QDEPTH];
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  rd_r, rd_nxt;
  event_t      ev;
  event_t      head;
  logic        push;
  logic        xfer;

  // Helpers
  logic [2:0]         aidx;
  logic [6:0]         abit;
  logic               acur;
  logic [15:0]        clamp_lo, clamp;
  logic signed [12:0] temp_x, warn_x, warn_lo;
  logic [18:0]        vib20, warn17;
  logic [15:0]        need;

  assign aidx = cmd.code - 3'd1;
  assign abit = 7'd1 << aidx;
  assign acur = |(aflag_r & abit);

  // Setpoint clamp: raise to minimum first, then cap at maximum
  assign clamp_lo = (sreq_r < MIN_SP) ? MIN_SP : sreq_r;
  assign clamp    = (clamp_lo > MAX_SP) ? MAX_SP : clamp_lo;

  // Protection compares
  assign temp_x  = {temp_r[11], temp_r};
  assign warn_x  = {cfg.temp_warn_level[11], cfg.temp_warn_level};
  assign warn_lo = warn_x - 13'sd30;
  assign vib20   = {1'b0, vib_r, 4'd0} + {3'd0, vib_r, 2'd0};
  assign warn17  = {1'b0, cfg.vib_warn_level, 4'd0} + {5'd0, cfg.vib_warn_level};
  assign need    = (cfg.vib_trip_ticks == 16'd0) ? 16'd1 : cfg.vib_trip_ticks;

  always_comb begin
    stat.req           = req_r;
    stat.mode          = mode_r;
    stat.latched_fault = lf_r;
    stat.gui_online    = gui_r;
    stat.btn_edge      = bedge_r;
    stat.prime_done    = (tim_r >= cfg.prime_ticks);
    stat.stopped       = (spd_r < cfg.stopped_speed);
    stat.reset_refused = (spd_r >= cfg.stopped_speed) ||
                         (temp_r >= cfg.temp_reset_level) || btn_r;
    stat.temp_trip     = (temp_r > cfg.temp_trip_level);
    stat.twarn_set     = !aflag_r[3] && (temp_x > warn_x);
    stat.twarn_clr     = aflag_r[3] && (temp_x < warn_lo);
    stat.vwarn_set     = !aflag_r[4] && (vib_r > cfg.vib_warn_level);
    stat.vwarn_clr     = aflag_r[4] && (vib20 < warn17);
    stat.vib_trip      = (vot_r >= need);
    stat.drained       = (rd_r == cnt_r);
  end

  // Operation decode
  always_comb begin
    mode_nxt  = mode_r;
    lf_nxt    = lf_r;
    sp_nxt    = sp_r;
    tim_nxt   = tim_r;
    vot_nxt   = vot_r;
    bwp_nxt   = bwp_r;
    gui_nxt   = gui_r;
    aflag_nxt = aflag_r;
    asev_nxt  = asev_r;
    bedge_nxt = bedge_r;
    turn_nxt  = turn_r;
    push      = 1'b0;
    ev        = mk_status(mode_r, lf_r, sp_r, PRIME_SP);
    case (cmd.op)
      OP_ENTER: begin
        mode_nxt = cmd.mode;
        lf_nxt   = cmd.code;
        tim_nxt  = '0;
        vot_nxt  = '0;
        push     = 1'b1;
        ev       = mk_status(cmd.mode, cmd.code, sp_r, PRIME_SP);
      end
      OP_STATUS: push = 1'b1;
      OP_SETPT: begin
        sp_nxt = clamp;
        push   = 1'b1;
        ev     = mk_status(mode_r, lf_r, clamp, PRIME_SP);
      end
      OP_ALARM: begin
        // Only a change of the flag is reported
        if (cmd.code != ALM_NONE && acur != cmd.on) begin
          aflag_nxt = cmd.on ? (aflag_r | abit) : (aflag_r & ~abit);
          asev_nxt  = cmd.sev ? (asev_r | abit) : (asev_r & ~abit);
          push      = 1'b1;
        end
        ev = mk_alarm(cmd.code, cmd.sev, cmd.on);
      end
      OP_REPUB: begin
        push = acur && (cmd.code != ALM_NONE);
        ev   = mk_alarm(cmd.code, |(asev_r & abit), 1'b1);
      end
      OP_TICK: begin
        if (tim_r != CNT_MAX) tim_nxt = tim_r + 16'd1;
        bedge_nxt = btn_r & ~bwp_r;
        bwp_nxt   = btn_r;
      end
      OP_TURN: begin
        turn_nxt = (mode_r == MODE_PRIMING) || (mode_r == MODE_RUNNING) ||
                   (mode_r == MODE_STOPPING);
      end
      OP_VCNT: begin
        if (turn_r && vib_r > cfg.vib_trip_level) begin
          if (vot_r != CNT_MAX) vot_nxt = vot_r + 16'd1;
        end else begin
          vot_nxt = '0;
        end
      end
      OP_GUI: gui_nxt = cmd.on;
      default: push = 1'b0;
    endcase
  end

  // Queue pointers
  assign xfer = out_valid & ~out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt  = rd_r;
    if (cmd.op == OP_LOAD) begin
      cnt_nxt = '0;
      rd_nxt  = '0;
    end else begin
      if (push && cnt_r != QFULL) cnt_nxt = cnt_r + 4'd1;
      if (xfer) rd_nxt = rd_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      lf_r    <= ALM_NONE;
      sp_r    <= DEF_SP;
      tim_r   <= '0;
      vot_r   <= '0;
      bwp_r   <= 1'b0;
      gui_r   <= 1'b0;
      aflag_r <= '0;
      asev_r  <= '0;
      bedge_r <= 1'b0;
      turn_r  <= 1'b0;
      cnt_r   <= '0;
      rd_r    <= '0;
    end else begin
      mode_r  <= mode_nxt;
      lf_r    <= lf_nxt;
      sp_r    <= sp_nxt;
      tim_r   <= tim_nxt;
      vot_r   <= vot_nxt;
      bwp_r   <= bwp_nxt;
      gui_r   <= gui_nxt;
      aflag_r <= aflag_nxt;
      asev_r  <= asev_nxt;
      bedge_r <= bedge_nxt;
      turn_r  <= turn_nxt;
      cnt_r   <= cnt_nxt;
      rd_r    <= rd_nxt;
    end
  end

  // Item capture and queue storage
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      req_r  <= in_req_type;
      sreq_r <= in_speed_request;
      spd_r  <= in_motor_speed;
      temp_r <= in_motor_temp;
      vib_r  <= in_vibration;
      btn_r  <= in_stop_button;
    end
    if (push && cnt_r != QFULL) q_r[cnt_r[2:0]] <= ev;
  end

  // Result channel
  assign head               = q_r[rd_r[2:0]];
  assign out_valid          = cmd.drain && (rd_r != cnt_r);
  assign out_event_kind     = head.kind;
  assign out_pump_state     = head.state;
  assign out_fault_code     = head.fault;
  assign out_setpoint       = head.setpoint;
  assign out_target_speed   = head.target;
  assign out_ramp_mode      = head.ramp;
  assign out_alarm_code     = head.acode;
  assign out_alarm_severity = head.sev;
  assign out_alarm_active   = head.active;
  assign out_last           = ((rd_r + 4'd1) == cnt_r);

endmodule

FILE: rtl/pump_supervisor_fsm.sv
// Pump supervisor top level: APB registers, sequencer and datapath.
// Depends on pss_pkg, pss_cfg, pss_ctrl and pss_dp.
//
//   Channel  Direction  Handshake            Carries
//   in_      in         in_valid / in_stall  request and measurements
//   out_     out        out_valid / out_stall status or alarm event, out_last
//   APB      in         psel/penable/pready  eight configuration registers
//
// An item passes through a capture step, a dispatch step and the further
// sequencer steps of its request. Its events (at most eight) are queued,
// then delivered one per cycle while out_stall is low, and the sequencer
// returns to idle once it sees the queue empty. in_stall is high from capture
// until the cycle after the last event transfer. out_stall holds the queue head
// in place. Reset is synchronous, active low.
module pump_supervisor_fsm #(
  parameter int MIN_SETPOINT     = 500,
  parameter int MAX_SETPOINT     = 3000,
  parameter int DEFAULT_SETPOINT = 1500,
  parameter int PRIME_SPEED      = 800
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_req_type,
  input  logic [15:0]        in_speed_request,
  input  logic [15:0]        in_motor_speed,
  input  logic signed [11:0] in_motor_temp,
  input  logic [13:0]        in_vibration,
  input  logic               in_stop_button,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_event_kind,
  output logic [2:0]         out_pump_state,
  output logic [2:0]         out_fault_code,
  output logic [15:0]        out_setpoint,
  output logic [15:0]        out_target_speed,
  output logic [1:0]         out_ramp_mode,
  output logic [2:0]         out_alarm_code,
  output logic               out_alarm_severity,
  output logic               out_alarm_active,
  output logic               out_last
);
  import pss_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  pss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pss_dp #(
    .MIN_SETPOINT     (MIN_SETPOINT),
    .MAX_SETPOINT     (MAX_SETPOINT),
    .DEFAULT_SETPOINT (DEFAULT_SETPOINT),
    .PRIME_SPEED      (PRIME_SPEED)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg),
    .stat               (stat),
    .in_req_type        (in_req_type),
    .in_speed_request   (in_speed_request),
    .in_motor_speed     (in_motor_speed),
    .in_motor_temp      (in_motor_temp),
    .in_vibration       (in_vibration),
    .in_stop_button     (in_stop_button),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_pump_state     (out_pump_state),
    .out_fault_code     (out_fault_code),
    .out_setpoint       (out_setpoint),
    .out_target_speed   (out_target_speed),
    .out_ramp_mode      (out_ramp_mode),
    .out_alarm_code     (out_alarm_code),
    .out_alarm_severity (out_alarm_severity),
    .out_alarm_active   (out_alarm_active),
    .out_last           (out_last)
  );

  // Events only go out while an item is in hand
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("event offered with no item in progress");

  // Accepting an item starts computation, never an immediate event
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("event offered in the cycle after item transfer");

  // Nothing follows the final event of an item
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("event offered after the last one of an item");

  // An alarm event never carries pump status fields
  a_alarm_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == EV_ALARM) |->
      (out_pump_state == 3'd0 && out_setpoint == 16'd0 &&
       out_alarm_code != ALM_NONE))
    else $error("malformed alarm event");

endmodule

FILE: tb/sv/pump_supervisor_fsm_check.sv
`timescale 1ns / 1ps
// Event checker for the pump supervisor: watches the APB, input and event channels,
// keeps its own copy of the supervisor state and compares every event transfer.
// Depends on pss_pkg for codes, mode_t and the register indexes.
module pump_supervisor_fsm_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_req_type,
  input  logic [15:0]        in_speed_request,
  input  logic [15:0]        in_motor_speed,
  input  logic signed [11:0] in_motor_temp,
  input  logic [13:0]        in_vibration,
  input  logic               in_stop_button,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_event_kind,
  input  logic [2:0]         out_pump_state,
  input  logic [2:0]         out_fault_code,
  input  logic [15:0]        out_setpoint,
  input  logic [15:0]        out_target_speed,
  input  logic [1:0]         out_ramp_mode,
  input  logic [2:0]         out_alarm_code,
  input  logic               out_alarm_severity,
  input  logic               out_alarm_active,
  input  logic               out_last,
  output int                 fail_count,
  output int                 outstanding
);
  import pss_pkg::*;

  localparam logic [15:0] SETPT_MIN     = 16'd500;
  localparam logic [15:0] SETPT_MAX     = 16'd3000;
  localparam logic [15:0] SETPT_DEFAULT = 16'd1500;
  localparam logic [15:0] PRIME_TARGET  = 16'd800;
  localparam int          EVENTS_MAX    = 8;

  typedef struct packed {
    logic        kind;
    logic [2:0]  state;
    logic [2:0]  fault;
    logic [15:0] setpoint;
    logic [15:0] target;
    logic [1:0]  ramp;
    logic [2:0]  acode;
    logic        sev;
    logic        active;
    logic        last;
  } pump_event_t;

  // Register copy, updated on each APB write
  logic signed [11:0] c_temp_trip, c_temp_warn, c_temp_reset;
  logic [13:0]        c_vib_warn, c_vib_trip;
  logic [15:0]        c_vib_ticks, c_prime, c_stop_speed;

  // Supervisor state
  mode_t       pump_mode;
  logic [2:0]  fault_latch;
  logic [15:0] setpt;
  logic [15:0] mode_ticks;
  logic [15:0] vib_over;
  logic        btn_prev;
  logic        gui_up;
  logic [6:0]  alm_on;
  logic [6:0]  alm_sev;

  pump_event_t item_events[$];
  pump_event_t pending_events[$];

  initial fail_count = 0;

  task automatic post_event(pump_event_t e);
    if (item_events.size() < EVENTS_MAX) item_events.push_back(e);
  endtask

  task automatic post_status();
    pump_event_t e;
    e = '0;
    e.kind     = EV_STATUS;
    e.state    = pump_mode;
    e.fault    = fault_latch;
    e.setpoint = setpt;
    if (pump_mode == MODE_PRIMING) e.target = PRIME_TARGET;
    else if (pump_mode == MODE_RUNNING) e.target = setpt;
    if (pump_mode == MODE_STOPPING) e.ramp = RAMP_DOWN;
    else if (pump_mode == MODE_FAULT) e.ramp = RAMP_COAST;
    else e.ramp = RAMP_UP;
    post_event(e);
  endtask

  task automatic post_alarm(logic [2:0] code, logic sev, logic on);
    pump_event_t e;
    e = '0;
    e.kind   = EV_ALARM;
    e.acode  = code;
    e.sev    = sev;
    e.active = on;
    post_event(e);
  endtask

  // Only a change of an alarm produces an event
  task automatic alarm_change(logic [2:0] code, logic sev, logic on);
    int b;
    if (code == ALM_NONE) return;
    b = int'(code) - 1;
    if (alm_on[b] == on) return;
    alm_on[b]  = on;
    alm_sev[b] = sev;
    post_alarm(code, sev, on);
  endtask

  task automatic alarm_replay();
    for (int c = 1; c <= 7; c++)
      if (alm_on[c-1]) post_alarm(3'(c), alm_sev[c-1], 1'b1);
  endtask

  task automatic move_to(mode_t m, logic [2:0] f);
    pump_mode   = m;
    fault_latch = f;
    mode_ticks  = '0;
    vib_over    = '0;
    post_status();
  endtask

  // First fault latches; a trip while faulted is ignored
  task automatic do_trip(logic [2:0] code);
    if (pump_mode == MODE_FAULT) return;
    alarm_change(code, 1'b1, 1'b1);
    move_to(MODE_FAULT, code);
  endtask

  // Works out the events caused by one input transfer and queues them
  task automatic predict(logic [3:0] req, logic [15:0] sreq, logic [15:0] spd,
                         logic signed [11:0] temp, logic [13:0] vib, logic btn);
    int          t, warn;
    logic [15:0] need, clamped;
    logic        turning;
    item_events.delete();
    t    = int'(temp);
    warn = int'(c_temp_warn);
    case (req)
      REQ_START: begin
        if (pump_mode == MODE_IDLE) move_to(MODE_PRIMING, ALM_NONE);
      end
      REQ_STOP: begin
        if (pump_mode == MODE_PRIMING || pump_mode == MODE_RUNNING)
          move_to(MODE_STOPPING, ALM_NONE);
      end
      REQ_ESTOP: do_trip(ALM_ESTOP_REMOTE);
      REQ_RESET: begin
        if (pump_mode == MODE_FAULT) begin
          if (spd >= c_stop_speed || t >= int'(c_temp_reset) || btn) begin
            post_status();
          end else begin
            alarm_change(fault_latch, 1'b1, 1'b0);
            move_to(MODE_IDLE, ALM_NONE);
          end
        end
      end
      REQ_SETSPD: begin
        clamped = sreq;
        if (clamped < SETPT_MIN) clamped = SETPT_MIN;
        if (clamped > SETPT_MAX) clamped = SETPT_MAX;
        setpt = clamped;
        post_status();
      end
      REQ_QUERY: begin
        post_status();
        alarm_replay();
      end
      REQ_TICK: begin
        need = (c_vib_ticks == '0) ? 16'd1 : c_vib_ticks;
        if (mode_ticks != 16'hFFFF) mode_ticks++;
        if (btn && !btn_prev) do_trip(ALM_ESTOP_LOCAL);
        btn_prev = btn;
        if (pump_mode == MODE_PRIMING) begin
          if (mode_ticks >= c_prime) move_to(MODE_RUNNING, ALM_NONE);
        end else if (pump_mode == MODE_STOPPING) begin
          if (spd < c_stop_speed) move_to(MODE_IDLE, ALM_NONE);
        end
        // turning is judged before the over-temperature trip
        turning = (pump_mode == MODE_PRIMING || pump_mode == MODE_RUNNING ||
                   pump_mode == MODE_STOPPING);
        if (t > int'(c_temp_trip)) do_trip(ALM_OVER_TEMP);
        // hysteresis: clears 3.0 C below the warning level
        if (!alm_on[ALM_TEMP_HIGH - 3'd1] && t > warn)
          alarm_change(ALM_TEMP_HIGH, 1'b0, 1'b1);
        else if (alm_on[ALM_TEMP_HIGH - 3'd1] && t < warn - 30)
          alarm_change(ALM_TEMP_HIGH, 1'b0, 1'b0);
        // hysteresis: clears below 0.85 of the warning level
        if (!alm_on[ALM_VIB_HIGH - 3'd1] && vib > c_vib_warn)
          alarm_change(ALM_VIB_HIGH, 1'b0, 1'b1);
        else if (alm_on[ALM_VIB_HIGH - 3'd1] && int'(vib) * 20 < int'(c_vib_warn) * 17)
          alarm_change(ALM_VIB_HIGH, 1'b0, 1'b0);
        if (turning && vib > c_vib_trip) begin
          if (vib_over != 16'hFFFF) vib_over++;
        end else begin
          vib_over = '0;
        end
        if (vib_over >= need) do_trip(ALM_VIB_TRIP);
      end
      REQ_GUI_HB: begin
        if (!gui_up) begin
          gui_up = 1'b1;
          alarm_change(ALM_GUI_LOST, 1'b0, 1'b0);
          post_status();
          alarm_replay();
        end
      end
      REQ_GUI_LOST: begin
        gui_up = 1'b0;
        if (pump_mode == MODE_PRIMING || pump_mode == MODE_RUNNING) begin
          alarm_change(ALM_GUI_LOST, 1'b0, 1'b1);
          move_to(MODE_STOPPING, ALM_NONE);
        end
      end
      default: ;
    endcase
    if (item_events.size() > 0) item_events[$].last = 1'b1;
    foreach (item_events[i]) pending_events.push_back(item_events[i]);
  endtask

  function automatic bit field_bad(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v === want_v) return 1'b0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    pump_event_t want;
    bit          bad;
    if (!rst_n) begin
      c_temp_trip  = 12'sd900;
      c_temp_warn  = 12'sd800;
      c_temp_reset = 12'sd600;
      c_vib_warn   = 14'd2000;
      c_vib_trip   = 14'd4000;
      c_vib_ticks  = 16'd20;
      c_prime      = 16'd40;
      c_stop_speed = 16'd50;
      pump_mode    = MODE_IDLE;
      fault_latch  = ALM_NONE;
      setpt        = SETPT_DEFAULT;
      mode_ticks   = '0;
      vib_over     = '0;
      btn_prev     = 1'b0;
      gui_up       = 1'b0;
      alm_on       = '0;
      alm_sev      = '0;
      pending_events.delete();
    end else begin
      // register write on the access phase
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_TEMP_TRIP:   c_temp_trip  = pwdata[11:0];
          REG_TEMP_WARN:   c_temp_warn  = pwdata[11:0];
          REG_TEMP_RESET:  c_temp_reset = pwdata[11:0];
          REG_VIB_WARN:    c_vib_warn   = pwdata[13:0];
          REG_VIB_TRIP:    c_vib_trip   = pwdata[13:0];
          REG_VIB_TICKS:   c_vib_ticks  = pwdata[15:0];
          REG_PRIME_TICKS: c_prime      = pwdata[15:0];
          REG_STOP_SPEED:  c_stop_speed = pwdata[15:0];
          default: ;
        endcase
      end
      // input transfer
      if (in_valid && !in_stall)
        predict(in_req_type, in_speed_request, in_motor_speed, in_motor_temp,
                in_vibration, in_stop_button);
      // event transfer
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event, kind %0d state %0d alarm %0d", $time,
                   out_event_kind, out_pump_state, out_alarm_code);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          bad = field_bad("event_kind", 16'(want.kind), 16'(out_event_kind))
              | field_bad("pump_state", 16'(want.state), 16'(out_pump_state))
              | field_bad("fault_code", 16'(want.fault), 16'(out_fault_code))
              | field_bad("setpoint", want.setpoint, out_setpoint)
              | field_bad("target_speed", want.target, out_target_speed)
              | field_bad("ramp_mode", 16'(want.ramp), 16'(out_ramp_mode))
              | field_bad("alarm_code", 16'(want.acode), 16'(out_alarm_code))
              | field_bad("alarm_severity", 16'(want.sev), 16'(out_alarm_severity))
              | field_bad("alarm_active", 16'(want.active), 16'(out_alarm_active))
              | field_bad("last", 16'(want.last), 16'(out_last));
          if (bad) fail_count++;
        end
      end
    end
    outstanding <= pending_events.size();
  end

endmodule

FILE: tb/sv/pump_supervisor_fsm_test.sv
`timescale 1ns / 1ps
// Top of the pump supervisor testbench: clock, reset, register set-up and stimulus.
// Depends on pss_pkg, pump_supervisor_fsm and pump_supervisor_fsm_check.
module pump_supervisor_fsm_test;
  import pss_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_req_type;
  logic [15:0]        in_speed_request;
  logic [15:0]        in_motor_speed;
  logic signed [11:0] in_motor_temp;
  logic [13:0]        in_vibration;
  logic               in_stop_button;
  logic               out_valid;
  logic               out_stall;
  logic               out_event_kind;
  logic [2:0]         out_pump_state;
  logic [2:0]         out_fault_code;
  logic [15:0]        out_setpoint;
  logic [15:0]        out_target_speed;
  logic [1:0]         out_ramp_mode;
  logic [2:0]         out_alarm_code;
  logic               out_alarm_severity;
  logic               out_alarm_active;
  logic               out_last;
  int                 fail_count;
  int                 outstanding;

  bit   calm;       // no idling on either side
  bit   hold_req;   // asks the receiver for one long hold-off
  logic btn_held;
  cfg_t cfg_now;

  pump_supervisor_fsm DUT (.*);

  pump_supervisor_fsm_check event_check (.*);

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Overall limit
  initial begin
    #10_000_000;
    $display("pump_supervisor_fsm_test NOT OK");
    $finish;
  end

  // Event receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int span;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        span = 300;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 10);
      end else begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 20);
      end
      repeat (span) @(posedge clk);
    end
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Register write: setup phase, access phase, then idle
  task automatic apb_write(logic [2:0] idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One input transfer, optionally followed by a gap
  task automatic send(logic [3:0] req, int sreq, int spd, int temp, int vib, logic btn);
    int gap;
    in_req_type      <= req;
    in_speed_request <= sreq[15:0];
    in_motor_speed   <= spd[15:0];
    in_motor_temp    <= temp[11:0];
    in_vibration     <= vib[13:0];
    in_stop_button   <= btn;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let every expected event arrive, then allow for an item with no events
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin : stimulus
    int          phase, r, temp, vib, spd, sreq, stop, warn, trip, rlev, vw, vt;
    logic [3:0]  req;
    logic        btn;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid         = 1'b0;
    in_req_type      = REQ_QUERY;
    in_speed_request = '0;
    in_motor_speed   = '0;
    in_motor_temp    = '0;
    in_vibration     = '0;
    in_stop_button   = 1'b0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    btn_held         = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 7; phase++) begin
      // no idling in the last phase, settled before its first item
      calm = (phase == 6);
      wait_quiet();
      // register settings for this phase
      case (phase)
        0: cfg_now = '{12'sd900, 12'sd800, 12'sd600, 14'd2000, 14'd4000,
                       16'd0, 16'd2, 16'd50};
        1: cfg_now = '{12'sd900, 12'sd800, 12'sd600, 14'd2000, 14'd4000,
                       16'd3, 16'd4, 16'd50};
        2: cfg_now = '{-12'sd400, -12'sd400, -12'sd400, 14'd0, 14'd0,
                       16'd1, 16'd0, 16'd0};
        3: cfg_now = '{12'sd2000, 12'sd2000, 12'sd2000, 14'd16000, 14'd16000,
                       16'd65535, 16'd65535, 16'd65535};
        4: cfg_now = '{12'sd300, 12'sd500, 12'sd700, 14'd9000, 14'd1000,
                       16'd2, 16'd1, 16'd1000};
        default: begin
          cfg_now.temp_trip_level  = 12'(int'($urandom_range(0, 2400)) - 400);
          cfg_now.temp_warn_level  = 12'(int'($urandom_range(0, 2400)) - 400);
          cfg_now.temp_reset_level = 12'(int'($urandom_range(0, 2400)) - 400);
          cfg_now.vib_warn_level   = 14'($urandom_range(0, 16000));
          cfg_now.vib_trip_level   = 14'($urandom_range(0, 16000));
          cfg_now.vib_trip_ticks   = 16'($urandom_range(1, 6));
          cfg_now.prime_ticks      = 16'($urandom_range(0, 8));
          cfg_now.stopped_speed    = 16'($urandom_range(0, 3000));
        end
      endcase
      apb_write(REG_TEMP_TRIP, int'(cfg_now.temp_trip_level));
      apb_write(REG_TEMP_WARN, int'(cfg_now.temp_warn_level));
      apb_write(REG_TEMP_RESET, int'(cfg_now.temp_reset_level));
      apb_write(REG_VIB_WARN, int'(cfg_now.vib_warn_level));
      apb_write(REG_VIB_TRIP, int'(cfg_now.vib_trip_level));
      apb_write(REG_VIB_TICKS, int'(cfg_now.vib_trip_ticks));
      apb_write(REG_PRIME_TICKS, int'(cfg_now.prime_ticks));
      apb_write(REG_STOP_SPEED, int'(cfg_now.stopped_speed));

      if (phase == 0) begin
        // directed: zero vibration trip ticks, two priming ticks
        send(4'hF, 16'hFFFF, 16'hFFFF, -400, 16000, 1'b1);  // unknown request
        send(REQ_QUERY, 0, 0, 0, 0, 1'b0);
        send(REQ_GUI_HB, 0, 0, 0, 0, 1'b0);
        send(REQ_GUI_HB, 0, 0, 0, 0, 1'b0);                 // already online
        send(REQ_SETSPD, 0, 0, 0, 0, 1'b0);                 // clamped up
        send(REQ_SETSPD, 16'hFFFF, 0, 0, 0, 1'b0);          // clamped down
        send(REQ_RESET, 0, 0, 0, 0, 1'b0);                  // ignored outside fault
        send(REQ_START, 0, 0, 0, 0, 1'b0);
        send(REQ_TICK, 0, 900, 850, 2500, 1'b0);            // both warnings raised
        send(REQ_TICK, 0, 900, 850, 2500, 1'b0);            // running, alarms unchanged
        send(REQ_TICK, 0, 900, 2000, 16000, 1'b0);          // over-temp, vib trip ignored
        send(REQ_ESTOP, 0, 0, 0, 0, 1'b0);                  // repeated trip
        send(REQ_RESET, 0, 1000, 0, 0, 1'b0);               // refused: turning
        send(REQ_RESET, 0, 0, 2000, 0, 1'b0);               // refused: hot
        send(REQ_RESET, 0, 0, 0, 0, 1'b1);                  // refused: button held
        send(REQ_TICK, 0, 0, 500, 0, 1'b0);                 // warnings cleared
        send(REQ_RESET, 0, 0, -400, 0, 1'b0);
        send(REQ_START, 0, 0, 0, 0, 1'b0);
        send(REQ_TICK, 0, 900, 0, 16000, 1'b0);             // one tick is enough
        send(REQ_RESET, 0, 49, 599, 0, 1'b0);               // just inside the limits
        send(REQ_START, 0, 0, 0, 0, 1'b0);
        send(REQ_GUI_LOST, 0, 0, 0, 0, 1'b0);
        send(REQ_TICK, 0, 50, 0, 0, 1'b0);                  // still stopping
        send(REQ_TICK, 0, 49, 0, 0, 1'b0);
        send(REQ_TICK, 0, 0, 0, 0, 1'b1);                   // local stop
        send(REQ_QUERY, 0, 0, 0, 0, 1'b0);
        send(REQ_RESET, 0, 0, 0, 0, 1'b0);
        send(REQ_GUI_HB, 0, 0, 0, 0, 1'b0);
      end else begin
        if (phase == 1) hold_req = 1'b1;
        repeat (66) begin
          warn = int'(cfg_now.temp_warn_level);
          trip = int'(cfg_now.temp_trip_level);
          rlev = int'(cfg_now.temp_reset_level);
          vw   = int'(cfg_now.vib_warn_level);
          vt   = int'(cfg_now.vib_trip_level);
          stop = int'(cfg_now.stopped_speed);
          // button held for a while, giving occasional edges
          if ($urandom_range(0, 99) < 8) btn_held = !btn_held;
          btn = btn_held;
          r = $urandom_range(0, 99);
          if (r < 35)      req = REQ_TICK;
          else if (r < 45) req = REQ_START;
          else if (r < 51) req = REQ_STOP;
          else if (r < 54) req = REQ_ESTOP;
          else if (r < 62) req = REQ_RESET;
          else if (r < 69) req = REQ_SETSPD;
          else if (r < 75) req = REQ_QUERY;
          else if (r < 83) req = REQ_GUI_HB;
          else if (r < 87) req = REQ_GUI_LOST;
          else if (r < 90) req = 4'($urandom_range(9, 15));
          else             req = REQ_TICK;
          sreq = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4000)
                                             : $urandom_range(0, 65535);
          if ($urandom_range(0, 1) == 0 && stop > 0) spd = $urandom_range(0, stop - 1);
          else spd = $urandom_range(0, 65535);
          // temperature mostly around the warning band
          r = $urandom_range(0, 99);
          if (r < 10)      temp = int'($urandom_range(0, 2400)) - 400;
          else if (r < 18) temp = clip(trip + int'($urandom_range(1, 100)), -400, 2000);
          else if (r < 90) temp = clip(warn - 50 + int'($urandom_range(0, 65)), -400, 2000);
          else             temp = clip(rlev - int'($urandom_range(1, 100)), -400, 2000);
          // vibration around the warning band or above the trip level
          r = $urandom_range(0, 99);
          if (r < 10)      vib = $urandom_range(0, 16000);
          else if (r < 40) vib = clip(vt + int'($urandom_range(1, 500)), 0, 16000);
          else vib = clip(vw * 17 / 20 - 100 + int'($urandom_range(0, vw * 3 / 20 + 300)),
                          0, 16000);
          // most resets meet the release conditions
          if (req == REQ_RESET && $urandom_range(0, 9) < 7) begin
            spd  = (stop > 0) ? $urandom_range(0, stop - 1) : 0;
            temp = clip(rlev - int'($urandom_range(1, 200)), -400, 2000);
            btn  = 1'b0;
          end
          send(req, sreq, spd, temp, vib, btn);
        end
      end
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("pump_supervisor_fsm_test OK");
    end else begin
      $display("pump_supervisor_fsm_test NOT OK");
    end
    $finish;
  end

endmodule
